### hw/rtl/mbp_pkg.sv
// Shared types and constants of the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbp_pkg;

   // MIDI status bytes
   localparam logic [7:0] ST_SYSEX        = 8'hF0;
   localparam logic [7:0] ST_MTC_QF       = 8'hF1;
   localparam logic [7:0] ST_SONG_POS     = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
   localparam logic [7:0] ST_TUNE_REQ     = 8'hF6;
   localparam logic [7:0] ST_EOX          = 8'hF7;
   localparam logic [7:0] ST_CLOCK        = 8'hF8;
   localparam logic [7:0] ST_START        = 8'hFA;
   localparam logic [7:0] ST_CONTINUE     = 8'hFB;
   localparam logic [7:0] ST_STOP         = 8'hFC;
   localparam logic [7:0] ST_ACTIVE_SENSE = 8'hFE;
   localparam logic [7:0] ST_RESET        = 8'hFF;

   // Message kinds
   localparam logic [4:0] KIND_NOTE_OFF   = 5'd0;
   localparam logic [4:0] KIND_SYSEX      = 5'd7;
   localparam logic [4:0] KIND_SYSEX_INT  = 5'd8;
   localparam logic [4:0] KIND_TUNE       = 5'd9;
   localparam logic [4:0] KIND_SYS_COMMON = 5'd10;
   localparam logic [4:0] KIND_CLOCK      = 5'd11;
   localparam logic [4:0] KIND_START      = 5'd12;
   localparam logic [4:0] KIND_CONTINUE   = 5'd13;
   localparam logic [4:0] KIND_STOP       = 5'd14;
   localparam logic [4:0] KIND_RESET      = 5'd15;
   localparam logic [4:0] KIND_UNKNOWN_RT = 5'd16;

   localparam logic [4:0] NO_CHANNEL  = 5'h1F;
   localparam logic [6:0] MAX_RESULTS = 7'd64;

   // Register indexes
   localparam logic CSR_CHANNEL_MASK = 1'b0;
   localparam logic CSR_SHOW_CLOCK   = 1'b1;

   // One message to send: byte 0 is first_byte, byte i>0 comes from store entry i-1
   typedef struct packed {
      logic       valid;
      logic [4:0] kind;
      logic [4:0] channel;
      logic [6:0] length;
      logic [7:0] first_byte;
   } msg_desc_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_FETCH,
      EMIT_SEND
   } emit_state_type;

endpackage

### hw/rtl/mbp_byte_store.sv
// Message byte store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module mbp_byte_store #(
   parameter int DEPTH = 31,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mbp_parser.sv
// Status tracking, running status and SysEx collection; issues message descriptors.
`timescale 1ns / 1ps

module mbp_parser
   import mbp_pkg::*;
#(
   parameter int MAX_RAW_BYTES = 32,
   parameter int AW            = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    rx_byte,
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [15:0]   csr_wdata,
   output logic          mem_we,
   output logic [AW-1:0] mem_addr,
   output logic [7:0]    mem_wdata,
   output msg_desc_type  desc_a,
   output msg_desc_type  desc_b
);

   localparam logic [6:0] MAX_CNT = 7'(MAX_RAW_BYTES);

   logic [7:0]  run_ff, run_in;
   logic [7:0]  cur_ff, cur_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  exp_ff, exp_in;
   logic        sysex_ff, sysex_in;
   logic [15:0] mask_ff;
   logic        clk_en_ff;

   logic [7:0]  cur_eff;
   logic [6:0]  cnt_eff;
   logic [6:0]  cnt_new;
   logic [6:0]  wr_addr_full;
   logic [1:0]  sc_expect;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         cur_ff   <= '0;
         cnt_ff   <= '0;
         exp_ff   <= '0;
         sysex_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         exp_ff   <= exp_in;
         sysex_ff <= sysex_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= 16'hFFFF;
         clk_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CHANNEL_MASK: mask_ff   <= csr_wdata;
            CSR_SHOW_CLOCK:   clk_en_ff <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   // a data byte with nothing pending picks up running status
   assign cur_eff = (cur_ff == 8'h00 && run_ff[7]) ? run_ff : cur_ff;
   assign cnt_eff = (cur_ff == 8'h00 && run_ff[7]) ? 7'd0 : cnt_ff;
   assign cnt_new = (cnt_eff < MAX_CNT) ? cnt_eff + 7'd1 : cnt_eff;

   always_comb begin
      case (rx_byte)
         ST_SONG_POS:            sc_expect = 2'd2;
         ST_MTC_QF, ST_SONG_SEL: sc_expect = 2'd1;
         default:                sc_expect = 2'd0;
      endcase
   end

   always_comb begin
      run_in       = run_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      sysex_in     = sysex_ff;
      mem_we       = 1'b0;
      wr_addr_full = cnt_ff - 7'd1;
      desc_a       = '0;
      desc_b       = '0;

      if (accept) begin
         if (rx_byte >= ST_CLOCK) begin
            // real-time: never touches parser state
            desc_a.valid      = 1'b1;
            desc_a.channel    = NO_CHANNEL;
            desc_a.length     = 7'd1;
            desc_a.first_byte = rx_byte;
            case (rx_byte)
               ST_CLOCK: begin
                  desc_a.valid = clk_en_ff;
                  desc_a.kind  = KIND_CLOCK;
               end
               ST_ACTIVE_SENSE: desc_a.valid = 1'b0;
               ST_START:        desc_a.kind  = KIND_START;
               ST_CONTINUE:     desc_a.kind  = KIND_CONTINUE;
               ST_STOP:         desc_a.kind  = KIND_STOP;
               ST_RESET:        desc_a.kind  = KIND_RESET;
               default:         desc_a.kind  = KIND_UNKNOWN_RT;
            endcase
         end else if (rx_byte[7]) begin
            if (sysex_ff) begin
               desc_a.valid      = 1'b1;
               desc_a.channel    = NO_CHANNEL;
               desc_a.first_byte = ST_SYSEX;
               if (rx_byte == ST_EOX) begin
                  desc_a.kind = KIND_SYSEX;
                  if (cnt_ff < MAX_CNT) begin
                     mem_we        = 1'b1;
                     desc_a.length = cnt_ff + 7'd1;
                  end else begin
                     desc_a.length = cnt_ff;
                  end
               end else begin
                  desc_a.kind   = KIND_SYSEX_INT;
                  desc_a.length = cnt_ff;
               end
               sysex_in = 1'b0;
            end
            if (rx_byte == ST_SYSEX) begin
               // F0 itself is the message prefix, data goes from entry 0
               sysex_in = 1'b1;
               cnt_in   = 7'd1;
               exp_in   = 2'd0;
               cur_in   = rx_byte;
               run_in   = 8'h00;
            end else if (rx_byte == ST_EOX) begin
               run_in   = 8'h00;
               cur_in   = 8'h00;
               cnt_in   = 7'd0;
               exp_in   = 2'd0;
               sysex_in = 1'b0;
            end else if (rx_byte >= ST_MTC_QF) begin
               cur_in = rx_byte;
               run_in = 8'h00;
               cnt_in = 7'd0;
               exp_in = sc_expect;
               if (sc_expect == 2'd0) begin
                  // dropped when an interrupted SysEx already filled the result budget
                  desc_b.valid      = !(desc_a.valid && desc_a.length >= MAX_RESULTS);
                  desc_b.kind       = (rx_byte == ST_TUNE_REQ) ? KIND_TUNE : KIND_SYS_COMMON;
                  desc_b.channel    = NO_CHANNEL;
                  desc_b.length     = 7'd1;
                  desc_b.first_byte = rx_byte;
                  cur_in            = 8'h00;
               end
            end else begin
               cur_in = rx_byte;
               run_in = rx_byte;
               cnt_in = 7'd0;
               exp_in = (rx_byte[7:4] == 4'hC || rx_byte[7:4] == 4'hD) ? 2'd1 : 2'd2;
            end
         end else if (sysex_ff) begin
            if (cnt_ff < MAX_CNT) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + 7'd1;
            end
         end else if (cur_eff[7]) begin
            wr_addr_full = cnt_eff;
            mem_we       = (cnt_eff < MAX_CNT);
            if (cnt_new >= {5'd0, exp_ff}) begin
               desc_a.first_byte = cur_eff;
               desc_a.length     = (cnt_new > MAX_CNT - 7'd1) ? MAX_CNT : cnt_new + 7'd1;
               if (cur_eff[7:4] == 4'hF) begin
                  desc_a.valid   = 1'b1;
                  desc_a.kind    = KIND_SYS_COMMON;
                  desc_a.channel = NO_CHANNEL;
               end else begin
                  desc_a.valid   = mask_ff[cur_eff[3:0]];
                  desc_a.channel = {1'b0, cur_eff[3:0]};
                  // Note On with zero velocity reads as Note Off
                  if (cur_eff[7:4] == 4'h9 && cnt_new >= 7'd2 && rx_byte == 8'h00) begin
                     desc_a.kind = KIND_NOTE_OFF;
                  end else begin
                     desc_a.kind = {2'b00, cur_eff[6:4]};
                  end
               end
               cur_in = 8'h00;
               cnt_in = 7'd0;
            end else begin
               cur_in = cur_eff;
               cnt_in = cnt_new;
            end
         end
      end
   end

   assign mem_addr  = wr_addr_full[AW-1:0];
   assign mem_wdata = rx_byte;

endmodule

### hw/rtl/mbp_emitter.sv
// Result sequencer: streams out up to two messages per request, one byte per result.
`timescale 1ns / 1ps

module mbp_emitter
   import mbp_pkg::*;
#(
   parameter int AW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  msg_desc_type  desc_a,
   input  msg_desc_type  desc_b,
   output logic          idle,
   output logic [AW-1:0] rd_addr,
   input  logic [7:0]    rd_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [4:0]    rsp_kind,
   output logic [4:0]    rsp_channel,
   output logic [6:0]    rsp_length,
   output logic [5:0]    rsp_index,
   output logic [7:0]    rsp_raw,
   output logic          rsp_last
);

   emit_state_type state_ff, state_in;
   msg_desc_type   cur_ff, cur_in;
   msg_desc_type   pend_ff, pend_in;
   logic [5:0]     idx_ff, idx_in;
   logic [5:0]     idx_m1;
   logic           is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   assign is_last = (({1'b0, idx_ff} + 7'd1) == cur_ff.length);
   assign idx_m1  = idx_ff - 6'd1;
   assign rd_addr = idx_m1[AW-1:0];

   // next state
   always_comb begin
      case (state_ff)
         EMIT_IDLE:
            state_in = (start && (desc_a.valid || desc_b.valid)) ? EMIT_FETCH : EMIT_IDLE;
         EMIT_FETCH:
            state_in = EMIT_SEND;
         EMIT_SEND: begin
            if (!rsp_ready) begin
               state_in = EMIT_SEND;
            end else if (is_last && !pend_ff.valid) begin
               state_in = EMIT_IDLE;
            end else begin
               state_in = EMIT_FETCH;
            end
         end
         default:
            state_in = EMIT_IDLE;
      endcase
   end

   // message and byte position
   always_comb begin
      cur_in  = cur_ff;
      pend_in = pend_ff;
      idx_in  = idx_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (start) begin
               idx_in = 6'd0;
               if (desc_a.valid) begin
                  cur_in  = desc_a;
                  pend_in = desc_b;
               end else begin
                  cur_in  = desc_b;
                  pend_in = '0;
               end
            end
         end
         EMIT_SEND: begin
            if (rsp_ready) begin
               if (is_last) begin
                  cur_in        = pend_ff;
                  pend_in.valid = 1'b0;
                  idx_in        = 6'd0;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      case (state_ff)
         EMIT_IDLE: begin
            idle      = 1'b1;
            rsp_valid = 1'b0;
         end
         EMIT_SEND: begin
            idle      = 1'b0;
            rsp_valid = 1'b1;
         end
         default: begin
            idle      = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_kind    = cur_ff.kind;
   assign rsp_channel = cur_ff.channel;
   assign rsp_length  = cur_ff.length;
   assign rsp_index   = idx_ff;
   assign rsp_raw     = (idx_ff == 6'd0) ? cur_ff.first_byte : rd_data;
   assign rsp_last    = is_last;

endmodule

### hw/rtl/midi_byte_stream_parser.sv
// MIDI byte stream parser top level: parser, byte store and result sequencer.
`timescale 1ns / 1ps
// A request is taken only while the sequencer is idle; the first result follows a fetch state.
// Each result byte goes through a store read (fetch), then a send that holds while rsp_tready is low,
// and a request produces at most 33 results with the default MAX_RAW_BYTES (an interrupted
// full SysEx plus a one-byte system common message).
// Synchronous reset clears parser state and loads the register defaults; req_tready is
// low during reset. The byte store is not cleared, entries are written before being read.

module midi_byte_stream_parser
   import mbp_pkg::*;
#(
   parameter int MAX_RAW_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // msg_kind, msg_channel, msg_length, byte_index, raw_byte
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int STORE_DEPTH = MAX_RAW_BYTES - 1;
   localparam int AW          = $clog2(STORE_DEPTH);

   msg_desc_type  desc_a;
   msg_desc_type  desc_b;
   logic          accept;
   logic          idle;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;
   logic [4:0]    rsp_kind;
   logic [4:0]    rsp_channel;
   logic [6:0]    rsp_length;
   logic [5:0]    rsp_index;
   logic [7:0]    rsp_raw;

   assign req_tready = idle & ~reset;
   assign accept     = req_tvalid & req_tready;

   mbp_parser #(
      .MAX_RAW_BYTES (MAX_RAW_BYTES),
      .AW            (AW)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .mem_we    (mem_we),
      .mem_addr  (mem_waddr),
      .mem_wdata (mem_wdata),
      .desc_a    (desc_a),
      .desc_b    (desc_b)
   );

   mbp_byte_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   mbp_emitter #(
      .AW (AW)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .desc_a      (desc_a),
      .desc_b      (desc_b),
      .idle        (idle),
      .rd_addr     (mem_raddr),
      .rd_data     (mem_rdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_channel (rsp_channel),
      .rsp_length  (rsp_length),
      .rsp_index   (rsp_index),
      .rsp_raw     (rsp_raw),
      .rsp_last    (rsp_tlast)
   );

   // [4:0] kind, [9:5] channel, [16:10] length, [22:17] index, [30:23] raw byte
   assign rsp_tdata = {1'b0, rsp_raw, rsp_index, rsp_length, rsp_channel, rsp_kind};

endmodule
